@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the block clock, quiet while reset is held
`define SDT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define SDT_ASSERT_IMP(label, cond, prop, msg) \
    `SDT_ASSERT(label, (cond) |-> (prop), msg)

// next-cycle implication
`define SDT_ASSERT_NEXT(label, cond, prop, msg) \
    `SDT_ASSERT(label, (cond) |=> (prop), msg)

`endif

@@ rtl/sdt_pkg.sv @@
package sdt_pkg;

    // framebuffer geometry
    localparam int FB_WIDTH  = 128;
    localparam int FB_HEIGHT = 128;
    localparam int PIXELS    = FB_WIDTH * FB_HEIGHT;
    localparam int ADDR_W    = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    // field widths
    localparam int KIND_W     = 2;
    localparam int POS_W      = 7;
    localparam int COLOR_W    = 32;
    localparam int DEPTH_W    = 24;
    localparam int STENCIL_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 24'hFF_FFFF;
    localparam logic [COLOR_W-1:0] ALPHA_ONES = 32'hFF00_0000;
    localparam logic [COLOR_W-1:0] RGB_BITS   = 32'h00FF_FFFF;

    // word kinds
    localparam logic [KIND_W-1:0] KIND_WRITE      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ_COLOR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ_DEPTH = 2'd2;

    // compare functions
    localparam logic [2:0] FN_NEVER    = 3'd0;
    localparam logic [2:0] FN_LESS     = 3'd1;
    localparam logic [2:0] FN_EQUAL    = 3'd2;
    localparam logic [2:0] FN_LEQUAL   = 3'd3;
    localparam logic [2:0] FN_GREATER  = 3'd4;
    localparam logic [2:0] FN_NOTEQUAL = 3'd5;
    localparam logic [2:0] FN_GEQUAL   = 3'd6;
    localparam logic [2:0] FN_ALWAYS   = 3'd7;

    // stencil ops
    localparam logic [2:0] OP_KEEP     = 3'd0;
    localparam logic [2:0] OP_ZERO     = 3'd1;
    localparam logic [2:0] OP_REPLACE  = 3'd2;
    localparam logic [2:0] OP_INCR     = 3'd3;
    localparam logic [2:0] OP_DECR     = 3'd4;
    localparam logic [2:0] OP_INVERT   = 3'd5;
    localparam logic [2:0] OP_INCRWRAP = 3'd6;
    localparam logic [2:0] OP_DECRWRAP = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_FUNC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_REF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_VMASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_WMASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_OPS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_FORMAT   = 3'd7;

    // one memory word per pixel
    typedef struct packed {
        logic [COLOR_W-1:0]   color;
        logic [DEPTH_W-1:0]   depth;
        logic [STENCIL_W-1:0] stencil;
    } pix_t;

    localparam pix_t CLEAR_PIX = '{color: '0, depth: DEPTH_MAX, stencil: '0};

    // a against b under compare function fn
    function automatic logic compare_fn(input logic [2:0] fn,
                                        input logic [DEPTH_W-1:0] a,
                                        input logic [DEPTH_W-1:0] b);
        logic r;
        case (fn)
            FN_NEVER:    r = 1'b0;
            FN_LESS:     r = (a < b);
            FN_EQUAL:    r = (a == b);
            FN_LEQUAL:   r = (a <= b);
            FN_GREATER:  r = (a > b);
            FN_NOTEQUAL: r = (a != b);
            FN_GEQUAL:   r = (a >= b);
            default:     r = 1'b1;
        endcase
        return r;
    endfunction

    // stencil update through the write mask
    function automatic logic [STENCIL_W-1:0] stencil_apply(
        input logic [2:0]           op,
        input logic [STENCIL_W-1:0] s,
        input logic [STENCIL_W-1:0] ref_val,
        input logic [STENCIL_W-1:0] wmask);
        logic [STENCIL_W-1:0] v;
        case (op)
            OP_ZERO:     v = '0;
            OP_REPLACE:  v = ref_val;
            OP_INCR:     v = (s == '1) ? s : s + 1'b1;
            OP_DECR:     v = (s == '0) ? s : s - 1'b1;
            OP_INVERT:   v = ~s;
            OP_INCRWRAP: v = s + 1'b1;
            OP_DECRWRAP: v = s - 1'b1;
            default:     v = s;
        endcase
        return (v & wmask) | (s & ~wmask);
    endfunction

    // alpha forced in xrgb mode
    function automatic logic [COLOR_W-1:0] format_color(input logic [COLOR_W-1:0] c,
                                                        input logic xrgb);
        return xrgb ? ((c & RGB_BITS) | ALPHA_ONES) : c;
    endfunction

endpackage

@@ rtl/sdt_if.sv @@
// fragment and read request channel
interface sdt_frag_if import sdt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [COLOR_W-1:0]   frag_color;
    logic [DEPTH_W-1:0]   frag_depth;

    modport source (output valid, kind, pos_x, pos_y, frag_color, frag_depth, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, frag_color, frag_depth, output ready);
endinterface

// result channel
interface sdt_result_if import sdt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [COLOR_W-1:0]   color_value;
    logic [DEPTH_W-1:0]   depth_value;
    logic                 stencil_passed;
    logic                 depth_passed;
    logic                 in_range;

    modport source (output valid, color_value, depth_value, stencil_passed, depth_passed,
                    in_range, input ready);
    modport sink   (input valid, color_value, depth_value, stencil_passed, depth_passed,
                    in_range, output ready);
endinterface

// configuration write channel
interface sdt_cfg_if import sdt_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/stencil_depth_test_unit.sv @@
// Stencil and depth test back end over a 128 x 128 framebuffer. Colour, depth and stencil
// of each pixel share one word of a single-port-read, single-port-write synchronous memory.
// A word is read in the cycle it is accepted; a write is modified and written back when it leaves
// the modify stage, so one fragment or read is taken per clock while no result is stalled,
// the same pixel included: the last written-back word is forwarded to the following one.
// A result sits in an output register and only a stalled result stops the pipeline. After
// reset a clearing pass writes every pixel before the first word is accepted; configuration
// writes are taken at any time with no wait.
`include "assert_macros.svh"

module stencil_depth_test_unit import sdt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sdt_frag_if.sink      frag,
    sdt_result_if.source  result,
    sdt_cfg_if.sink       cfg
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

    // configuration registers
    logic                 stencil_enable_reg;
    logic [2:0]           stencil_func_reg;
    logic [STENCIL_W-1:0] stencil_ref_reg;
    logic [STENCIL_W-1:0] stencil_vmask_reg;
    logic [STENCIL_W-1:0] stencil_wmask_reg;
    logic [8:0]           stencil_ops_reg;
    logic [3:0]           depth_mode_reg;
    logic                 color_format_reg;

    // clearing pass
    logic                 clearing_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;

    // pixel memory
    pix_t                 pix_mem [PIXELS];
    pix_t                 mem_rdata_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    pix_t                 mem_wdata;

    // modify stage
    logic                 s1_valid_reg;
    logic [KIND_W-1:0]    s1_kind_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic                 s1_inr_reg;
    logic [COLOR_W-1:0]   s1_color_reg;
    logic [DEPTH_W-1:0]   s1_depth_reg;

    // forwarding of the last written-back word
    logic                 fwd_valid_reg;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    pix_t                 fwd_data_reg;

    // output register
    logic                 res_valid_reg;
    logic [COLOR_W-1:0]   res_color_reg;
    logic [DEPTH_W-1:0]   res_depth_reg;
    logic                 res_spass_reg;
    logic                 res_dpass_reg;
    logic                 res_inr_reg;

    logic                 frag_fire;
    logic                 s1_advance;
    logic                 s1_fire;
    logic                 frag_inr;
    logic [ADDR_W-1:0]    frag_addr;
    pix_t                 cur_pix;
    pix_t                 new_pix;
    logic                 s1_is_write;
    logic                 pix_write;
    logic                 spass;
    logic                 dpass;
    logic [COLOR_W-1:0]   res_color_next;
    logic [DEPTH_W-1:0]   res_depth_next;

    // handshakes
    assign s1_advance = !res_valid_reg || result.ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign frag.ready = !clearing_reg && (!s1_valid_reg || s1_advance);
    assign frag_fire  = frag.valid && frag.ready;
    assign cfg.ready  = 1'b1;

    // pixel address
    assign frag_inr  = (32'(frag.pos_x) < FB_WIDTH) && (32'(frag.pos_y) < FB_HEIGHT);
    assign frag_addr = frag_inr ? ADDR_W'(32'(frag.pos_y) * FB_WIDTH + 32'(frag.pos_x))
                                : '0;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stencil_enable_reg <= 1'b0;
            stencil_func_reg   <= FN_ALWAYS;
            stencil_ref_reg    <= '0;
            stencil_vmask_reg  <= '1;
            stencil_wmask_reg  <= '1;
            stencil_ops_reg    <= '0;
            depth_mode_reg     <= 4'd1;
            color_format_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_STENCIL_ENABLE: stencil_enable_reg <= cfg.wdata[0];
                REG_STENCIL_FUNC:   stencil_func_reg   <= cfg.wdata[2:0];
                REG_STENCIL_REF:    stencil_ref_reg    <= cfg.wdata[STENCIL_W-1:0];
                REG_STENCIL_VMASK:  stencil_vmask_reg  <= cfg.wdata[STENCIL_W-1:0];
                REG_STENCIL_WMASK:  stencil_wmask_reg  <= cfg.wdata[STENCIL_W-1:0];
                REG_STENCIL_OPS:    stencil_ops_reg    <= cfg.wdata[8:0];
                REG_DEPTH_MODE:     depth_mode_reg     <= cfg.wdata[3:0];
                REG_COLOR_FORMAT:   color_format_reg   <= cfg.wdata[0];
                default:            stencil_enable_reg <= stencil_enable_reg;
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // memory read, registered data
    always_ff @(posedge clk)
    begin
        if (frag_fire)
        begin
            mem_rdata_reg <= pix_mem[frag_addr];
        end
    end

    // memory write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pix_mem[mem_waddr] <= mem_wdata;
        end
    end

    // modify stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frag_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frag_fire)
        begin
            s1_kind_reg  <= frag.kind;
            s1_addr_reg  <= frag_addr;
            s1_inr_reg   <= frag_inr;
            s1_color_reg <= frag.frag_color;
            s1_depth_reg <= frag.frag_depth;
        end
    end

    // current pixel, forwarded when the previous write-back hit it
    assign cur_pix = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg
                                                                      : mem_rdata_reg;

    // stencil test, depth test and updates
    always_comb
    begin
        new_pix = cur_pix;
        spass   = 1'b1;
        dpass   = 1'b0;
        if (stencil_enable_reg)
        begin
            spass = compare_fn(stencil_func_reg,
                               DEPTH_W'(stencil_ref_reg & stencil_vmask_reg),
                               DEPTH_W'(cur_pix.stencil & stencil_vmask_reg));
        end
        if (!spass)
        begin
            new_pix.stencil = stencil_apply(stencil_ops_reg[2:0], cur_pix.stencil,
                                            stencil_ref_reg, stencil_wmask_reg);
        end
        else
        begin
            dpass = 1'b1;
            if (depth_mode_reg[3])
            begin
                dpass = compare_fn(depth_mode_reg[2:0], s1_depth_reg, cur_pix.depth);
                if (dpass)
                begin
                    new_pix.depth = s1_depth_reg;
                end
            end
            if (stencil_enable_reg)
            begin
                new_pix.stencil = stencil_apply(dpass ? stencil_ops_reg[8:6]
                                                      : stencil_ops_reg[5:3],
                                                cur_pix.stencil, stencil_ref_reg,
                                                stencil_wmask_reg);
            end
            if (dpass)
            begin
                new_pix.color = format_color(s1_color_reg, color_format_reg);
            end
        end
    end

    assign s1_is_write = (s1_kind_reg == KIND_WRITE) && s1_inr_reg;
    assign pix_write   = s1_fire && s1_is_write;

    // write port: clearing pass or write-back
    assign mem_we    = clearing_reg || pix_write;
    assign mem_waddr = clearing_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wdata = clearing_reg ? CLEAR_PIX : new_pix;

    // forwarding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (pix_write)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_write)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_pix;
        end
    end

    // result word
    always_comb
    begin
        res_color_next = '0;
        res_depth_next = '0;
        case (s1_kind_reg)
            KIND_READ_COLOR:
            begin
                res_color_next = s1_inr_reg ? format_color(cur_pix.color, color_format_reg)
                                            : '0;
            end
            KIND_READ_DEPTH:
            begin
                res_depth_next = s1_inr_reg ? cur_pix.depth : DEPTH_MAX;
            end
            default:
            begin
                res_color_next = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_color_reg <= res_color_next;
            res_depth_reg <= res_depth_next;
            res_spass_reg <= s1_is_write && spass;
            res_dpass_reg <= s1_is_write && spass && dpass;
            res_inr_reg   <= s1_inr_reg;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.color_value    = res_color_reg;
    assign result.depth_value    = res_depth_reg;
    assign result.stencil_passed = res_spass_reg;
    assign result.depth_passed   = res_dpass_reg;
    assign result.in_range       = res_inr_reg;

    // checks
    `SDT_ASSERT_NEXT(a_accept_fills_stage, frag_fire, s1_valid_reg, "accepted word lost")
    `SDT_ASSERT_IMP(a_clear_idle, clearing_reg, !s1_valid_reg && !res_valid_reg, "busy in clear")
    `SDT_ASSERT_IMP(a_dpass_spass, res_valid_reg && res_dpass_reg, res_spass_reg, "dpass alone")
    `SDT_ASSERT_NEXT(a_stage_moves_to_output, s1_fire, res_valid_reg, "word not registered")

endmodule

@@ bench/depth_stencil_checker.sv @@
`timescale 1ns / 1ps

module depth_stencil_checker import sdt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sdt_frag_if    frag,
    sdt_result_if  result,
    sdt_cfg_if     cfg,
    output int     mismatches,
    output int     outstanding
);

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [DEPTH_W-1:0] depth;
        logic               spass;
        logic               dpass;
        logic               inr;
    } outcome_t;

    // shadow framebuffer
    logic [COLOR_W-1:0]   color_mem [PIXELS];
    logic [DEPTH_W-1:0]   depth_mem [PIXELS];
    logic [STENCIL_W-1:0] sten_mem  [PIXELS];

    // shadow copy of the register file
    logic                 st_en;
    logic [2:0]           st_func;
    logic [STENCIL_W-1:0] st_ref;
    logic [STENCIL_W-1:0] st_vmask;
    logic [STENCIL_W-1:0] st_wmask;
    logic [8:0]           st_ops;
    logic [3:0]           z_mode;
    logic                 xrgb;

    outcome_t due_q [$];

    // a against b under the given compare function
    function automatic logic holds(input logic [2:0] fn,
                                   input logic [DEPTH_W-1:0] a,
                                   input logic [DEPTH_W-1:0] b);
        case (fn)
            FN_NEVER:    return 1'b0;
            FN_LESS:     return a < b;
            FN_EQUAL:    return a == b;
            FN_LEQUAL:   return a <= b;
            FN_GREATER:  return a > b;
            FN_NOTEQUAL: return a != b;
            FN_GEQUAL:   return a >= b;
            default:     return 1'b1;
        endcase
    endfunction

    // new stencil value, only write-mask bits may change
    function automatic logic [STENCIL_W-1:0] next_stencil(input logic [2:0] op,
                                                          input logic [STENCIL_W-1:0] s);
        logic [STENCIL_W-1:0] v;
        v = s;
        case (op)
            OP_ZERO:     v = '0;
            OP_REPLACE:  v = st_ref;
            OP_INCR:     v = (s == 8'hFF) ? s : s + 8'd1;
            OP_DECR:     v = (s == 8'h00) ? s : s - 8'd1;
            OP_INVERT:   v = ~s;
            OP_INCRWRAP: v = s + 8'd1;
            OP_DECRWRAP: v = s - 8'd1;
            default:     v = s;
        endcase
        return (v & st_wmask) | (s & ~st_wmask);
    endfunction

    // colour as seen through the current format
    function automatic logic [COLOR_W-1:0] shown(input logic [COLOR_W-1:0] c);
        return xrgb ? {8'hFF, c[23:0]} : c;
    endfunction

    // effect of one accepted word on the shadow stores, and its result
    function automatic outcome_t resolve(input logic [KIND_W-1:0]  kind,
                                         input logic [POS_W-1:0]   x,
                                         input logic [POS_W-1:0]   y,
                                         input logic [COLOR_W-1:0] col,
                                         input logic [DEPTH_W-1:0] dep);
        outcome_t             o;
        int                   idx;
        logic [STENCIL_W-1:0] s;
        logic                 sp;
        logic                 dp;
        o = '{color: '0, depth: '0, spass: 1'b0, dpass: 1'b0, inr: 1'b1};
        idx = int'(y) * FB_WIDTH + int'(x);
        if (kind == KIND_WRITE) begin
            s = sten_mem[idx];
            sp = 1'b1;
            if (st_en) begin
                sp = holds(st_func, {16'd0, st_ref & st_vmask}, {16'd0, s & st_vmask});
                if (!sp)
                    sten_mem[idx] = next_stencil(st_ops[2:0], s);
            end
            if (sp) begin
                dp = 1'b1;
                o.spass = 1'b1;
                if (z_mode[3]) begin
                    dp = holds(z_mode[2:0], dep, depth_mem[idx]);
                    if (dp)
                        depth_mem[idx] = dep;
                end
                if (st_en)
                    sten_mem[idx] = next_stencil(dp ? st_ops[8:6] : st_ops[5:3], s);
                if (dp) begin
                    color_mem[idx] = shown(col);
                    o.dpass = 1'b1;
                end
            end
        end else if (kind == KIND_READ_COLOR) begin
            o.color = shown(color_mem[idx]);
        end else if (kind == KIND_READ_DEPTH) begin
            o.depth = depth_mem[idx];
        end
        return o;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < PIXELS; i++)
            begin
                color_mem[i] = '0;
                depth_mem[i] = DEPTH_MAX;
                sten_mem[i]  = '0;
            end
            st_en       = 1'b0;
            st_func     = FN_ALWAYS;
            st_ref      = '0;
            st_vmask    = 8'hFF;
            st_wmask    = 8'hFF;
            st_ops      = '0;
            z_mode      = 4'h1;
            xrgb        = 1'b0;
            mismatches  = 0;
            due_q.delete();
            outstanding = 0;
        end
        else
        begin
            // result word against the oldest expectation
            if (result.valid && result.ready)
            begin
                if (due_q.size() == 0)
                    report("unexpected result", 32'd0, 32'd0);
                else
                begin
                    want = due_q.pop_front();
                    if (result.color_value !== want.color)
                        report("color_value", result.color_value, want.color);
                    if (result.depth_value !== want.depth)
                        report("depth_value", {8'd0, result.depth_value}, {8'd0, want.depth});
                    if (result.stencil_passed !== want.spass)
                        report("stencil_passed", {31'd0, result.stencil_passed},
                               {31'd0, want.spass});
                    if (result.depth_passed !== want.dpass)
                        report("depth_passed", {31'd0, result.depth_passed},
                               {31'd0, want.dpass});
                    if (result.in_range !== want.inr)
                        report("in_range", {31'd0, result.in_range}, {31'd0, want.inr});
                end
            end

            // register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    REG_STENCIL_ENABLE: st_en    = cfg.wdata[0];
                    REG_STENCIL_FUNC:   st_func  = cfg.wdata[2:0];
                    REG_STENCIL_REF:    st_ref   = cfg.wdata[7:0];
                    REG_STENCIL_VMASK:  st_vmask = cfg.wdata[7:0];
                    REG_STENCIL_WMASK:  st_wmask = cfg.wdata[7:0];
                    REG_STENCIL_OPS:    st_ops   = cfg.wdata[8:0];
                    REG_DEPTH_MODE:     z_mode   = cfg.wdata[3:0];
                    default:            xrgb     = cfg.wdata[0];
                endcase
            end

            // fragment or read word
            if (frag.valid && frag.ready)
                due_q.push_back(resolve(frag.kind, frag.pos_x, frag.pos_y,
                                        frag.frag_color, frag.frag_depth));

            outstanding = due_q.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sdt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 60000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 115;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   idle_cycles = 0;
    bit   calm = 1'b0;

    sdt_frag_if   frag_ch ();
    sdt_result_if res_ch ();
    sdt_cfg_if    cfg_ch ();

    stencil_depth_test_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frag   (frag_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    depth_stencil_checker checks (
        .clk         (clk),
        .rst_n       (rst_n),
        .frag        (frag_ch),
        .result      (res_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
        res_ch.ready <= calm || ($urandom_range(99) >= 35);

    // stall watchdog, also covers the clearing pass after reset
    always @(posedge clk)
    begin
        if ((frag_ch.valid && frag_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[stencil_depth_test_unit] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one register write, valid left high for the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_regs(input logic en, input logic [2:0] fn, input logic [7:0] rf,
                             input logic [7:0] vm, input logic [7:0] wm, input logic [8:0] ops,
                             input logic [3:0] dm, input logic fmt);
        write_reg(REG_STENCIL_ENABLE, {8'd0, en});
        write_reg(REG_STENCIL_FUNC,   {6'd0, fn});
        write_reg(REG_STENCIL_REF,    {1'b0, rf});
        write_reg(REG_STENCIL_VMASK,  {1'b0, vm});
        write_reg(REG_STENCIL_WMASK,  {1'b0, wm});
        write_reg(REG_STENCIL_OPS,    ops);
        write_reg(REG_DEPTH_MODE,     {5'd0, dm});
        write_reg(REG_COLOR_FORMAT,   {8'd0, fmt});
        cfg_ch.valid <= 1'b0;
    endtask

    // one fragment or read word, with an occasional gap ahead of it
    task automatic push_word(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [COLOR_W-1:0] c,
                             input logic [DEPTH_W-1:0] d);
        if (!calm && $urandom_range(99) < 35)
        begin
            frag_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 2))
                @(posedge clk);
        end
        frag_ch.valid      <= 1'b1;
        frag_ch.kind       <= k;
        frag_ch.pos_x      <= x;
        frag_ch.pos_y      <= y;
        frag_ch.frag_color <= c;
        frag_ch.frag_depth <= d;
        @(posedge clk);
        while (!frag_ch.ready)
            @(posedge clk);
    endtask

    // stop sending and wait for every result to come back
    task automatic settle();
        frag_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // mostly writes into a few hot pixels so tests see earlier updates
    task automatic random_word();
        logic [KIND_W-1:0]  k;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [DEPTH_W-1:0] d;
        int                 roll;
        roll = $urandom_range(99);
        if (roll < 55)
            k = KIND_WRITE;
        else if (roll < 75)
            k = KIND_READ_COLOR;
        else if (roll < 95)
            k = KIND_READ_DEPTH;
        else
            k = KIND_UNUSED;
        if ($urandom_range(99) < 70)
        begin
            x = POS_W'($urandom_range(3));
            y = POS_W'($urandom_range(3));
        end
        else
        begin
            x = POS_W'($urandom_range(127));
            y = POS_W'($urandom_range(127));
        end
        roll = $urandom_range(99);
        if (roll < 15)
            d = '0;
        else if (roll < 30)
            d = DEPTH_MAX;
        else if (roll < 55)
            d = DEPTH_W'(24'h7F_FFFE + $urandom_range(3));
        else
            d = DEPTH_W'($urandom_range(24'hFF_FFFF));
        push_word(k, x, y, $urandom, d);
    endtask

    // per-phase settings, all-low and all-high first
    task automatic random_regs(input int phase);
        if (phase == 0)
            load_regs(1'b0, FN_NEVER, 8'h00, 8'h00, 8'h00, 9'h000, 4'h0, 1'b0);
        else if (phase == 1)
            load_regs(1'b1, FN_ALWAYS, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 4'hF, 1'b1);
        else
            load_regs($urandom_range(99) < 80, 3'($urandom_range(7)), 8'($urandom_range(255)),
                      ($urandom_range(1) != 0) ? 8'hFF : 8'($urandom_range(255)),
                      ($urandom_range(1) != 0) ? 8'hFF : 8'($urandom_range(255)),
                      9'($urandom_range(511)),
                      {$urandom_range(99) < 80, 3'($urandom_range(7))},
                      1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        frag_ch.valid      <= 1'b0;
        frag_ch.kind       <= KIND_WRITE;
        frag_ch.pos_x      <= '0;
        frag_ch.pos_y      <= '0;
        frag_ch.frag_color <= '0;
        frag_ch.frag_depth <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.reg_index   <= REG_STENCIL_ENABLE;
        cfg_ch.wdata       <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: stencil off, depth test off
        load_regs(1'b0, FN_ALWAYS, 8'h00, 8'hFF, 8'hFF, 9'h000, {1'b0, FN_LESS}, 1'b0);
        push_word(KIND_WRITE, 7'd0, 7'd0, 32'hFFFF_FFFF, 24'h00_0000);
        push_word(KIND_WRITE, 7'd127, 7'd127, 32'h0000_0000, DEPTH_MAX);
        push_word(KIND_READ_COLOR, 7'd0, 7'd0, 32'h0, 24'h0);
        push_word(KIND_READ_DEPTH, 7'd0, 7'd0, 32'h0, 24'h0);
        push_word(KIND_UNUSED, 7'd64, 7'd64, 32'hFFFF_FFFF, DEPTH_MAX);
        push_word(KIND_READ_COLOR, 7'd127, 7'd127, 32'h0, 24'h0);
        settle();

        // depth less, xrgb, zpass saturating up, zfail saturating down
        load_regs(1'b1, FN_ALWAYS, 8'hFF, 8'hFF, 8'hFF, {OP_INCR, OP_DECR, OP_INVERT},
                  {1'b1, FN_LESS}, 1'b1);
        push_word(KIND_WRITE, 7'd1, 7'd1, 32'h1234_5678, 24'h80_0000);
        push_word(KIND_WRITE, 7'd1, 7'd1, 32'hAAAA_AAAA, 24'h90_0000);
        push_word(KIND_WRITE, 7'd1, 7'd1, 32'h5555_5555, 24'h80_0000);
        push_word(KIND_READ_COLOR, 7'd1, 7'd1, 32'h0, 24'h0);
        push_word(KIND_READ_DEPTH, 7'd1, 7'd1, 32'h0, 24'h0);
        settle();

        // stencil never passes, replace through a partial write mask
        load_regs(1'b1, FN_NEVER, 8'h5A, 8'h00, 8'h0F, {OP_INCRWRAP, OP_DECRWRAP, OP_REPLACE},
                  {1'b1, FN_ALWAYS}, 1'b0);
        push_word(KIND_WRITE, 7'd1, 7'd1, 32'hDEAD_BEEF, 24'h00_0001);
        push_word(KIND_WRITE, 7'd2, 7'd2, 32'hDEAD_BEEF, 24'h00_0001);
        settle();

        // stencil equal, depth greater, wrap up on pass and zero on stencil fail
        load_regs(1'b1, FN_EQUAL, 8'h0A, 8'hFF, 8'hFF, {OP_INCRWRAP, OP_DECRWRAP, OP_ZERO},
                  {1'b1, FN_GREATER}, 1'b0);
        push_word(KIND_WRITE, 7'd1, 7'd1, 32'h0102_0304, DEPTH_MAX);
        push_word(KIND_WRITE, 7'd1, 7'd1, 32'h0506_0708, 24'h00_0000);
        settle();

        // stencil gequal, depth notequal, wrap below zero and saturate at the top
        load_regs(1'b1, FN_GEQUAL, 8'hFF, 8'hFF, 8'hFF, {OP_INCR, OP_DECRWRAP, OP_KEEP},
                  {1'b1, FN_NOTEQUAL}, 1'b0);
        push_word(KIND_WRITE, 7'd3, 7'd3, 32'h1111_1111, 24'h00_0000);
        push_word(KIND_WRITE, 7'd3, 7'd3, 32'h2222_2222, 24'h00_0000);
        push_word(KIND_WRITE, 7'd3, 7'd3, 32'h3333_3333, 24'h00_0000);
        push_word(KIND_WRITE, 7'd3, 7'd3, 32'h4444_4444, 24'h00_0005);
        push_word(KIND_READ_DEPTH, 7'd3, 7'd3, 32'h0, 24'h0);

        // random phases, one of them without any idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            calm = (phase == 5);
            random_regs(phase);
            repeat (PHASE_WORDS)
                random_word();
        end
        settle();
        calm = 1'b0;
        repeat (8)
            @(posedge clk);

        if (mismatches == 0)
            $display("[stencil_depth_test_unit] OK");
        else
            $display("[stencil_depth_test_unit] ERROR");
        $finish;
    end

endmodule
